// ----- rtl/ptsc_pkg.sv -----
// Shared widths, register codes, status struct and helpers for the path-to-stepper block.
package ptsc_pkg;

   // fixed field widths
   localparam int CoordW   = 32;
   localparam int ScaleW   = 32;
   localparam int DeltaW   = 16;
   localparam int DurW     = 32;
   localparam int ProdW    = 2 * CoordW;
   // sum of two squares plus headroom, padded to an even bit count
   localparam int RadW     = ProdW + 2;
   localparam int RootW    = RadW / 2;
   // distance shifted up by the Q16.16 fraction before division by speed
   localparam int FracW    = 16;
   localparam int DvdW     = RootW + FracW;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 32;

   localparam logic [ScaleW-1:0] ScaleReset = 32'h0001_0000;

   // configuration register codes
   typedef enum logic [CsrAddrW-1:0] {
      CSR_X_SCALE = 2'd0,
      CSR_Y_SCALE = 2'd1,
      CSR_SPEED   = 2'd2
   } csr_addr_type;

   // status of an iterative unit towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // unsigned add, saturating at all ones
   function automatic logic [DurW-1:0] sat_add(input logic [DurW-1:0] a,
                                                input logic [DurW-1:0] b);
      logic [DurW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DurW] ? {DurW{1'b1}} : s[DurW-1:0];
   endfunction

endpackage

// ----- rtl/ptsc_req_if.sv -----
// Input channel: one path point per beat.
interface ptsc_req_if;
   import ptsc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     start_req;
   logic signed [CoordW-1:0] left_x;
   logic signed [CoordW-1:0] left_y;
   logic signed [CoordW-1:0] right_x;
   logic signed [CoordW-1:0] right_y;

   modport source (output valid, start_req, left_x, left_y, right_x, right_y,
                   input ready);
   modport sink   (input valid, start_req, left_x, left_y, right_x, right_y,
                   output ready);
endinterface

// ----- rtl/ptsc_rsp_if.sv -----
// Result channel: one stepper command per beat.
interface ptsc_rsp_if;
   import ptsc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic signed [DeltaW-1:0] delta_left_x;
   logic signed [DeltaW-1:0] delta_left_y;
   logic signed [DeltaW-1:0] delta_right_x;
   logic signed [DeltaW-1:0] delta_right_y;
   logic [DurW-1:0]          duration;

   modport source (output valid, kind, delta_left_x, delta_left_y, delta_right_x,
                   delta_right_y, duration, input ready);
   modport sink   (input valid, kind, delta_left_x, delta_left_y, delta_right_x,
                   delta_right_y, duration, output ready);
endinterface

// ----- rtl/ptsc_csr_if.sv -----
// Configuration write channel: register address and data per beat.
interface ptsc_csr_if;
   import ptsc_pkg::*;

   logic                valid;
   logic                ready;
   logic [CsrAddrW-1:0] addr;
   logic [CsrDataW-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ----- rtl/path_to_stepper_commands.sv -----
// Top level: sequencer turning two-sided path points into stepper commands.
// Each path point passes the shared multiplier, two square roots and the division by speed,
// plus accept and finish; a start point only passes the multiplier.
// Throughput: one point at a time; the next point is taken once the previous one has finished,
// and a finished command waits in the output register while the next point is worked on.
// Reset (synchronous, active high) restores the register defaults and clears positions,
// previous point and skipped time.
module path_to_stepper_commands
   import ptsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ptsc_req_if.sink    req_ch,
   ptsc_rsp_if.source  rsp_ch,
   ptsc_csr_if.sink    csr_ch
);

   localparam int MulLat  = 2;
   localparam int AxisOps = 4;
   localparam int AllOps  = 8;
   localparam int CntW    = 4;
   localparam int WideW   = CoordW + 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROOT_L,
      ST_ROOT_R,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [ScaleW-1:0] x_scale_ff;
   logic [ScaleW-1:0] y_scale_ff;
   logic [ScaleW-1:0] speed_ff;

   // point and path state
   logic [CoordW-1:0] pt_ff   [4];
   logic [CoordW-1:0] prev_ff [4];
   logic [CoordW-1:0] pos_ff  [4];
   logic [DeltaW-1:0] delta_ff[4];
   logic [RadW-1:0]   sum_ff  [2];
   logic              start_ff;
   logic [DurW-1:0]   skip_ff;
   logic [RootW-1:0]  dist_l_ff;
   logic [DurW-1:0]   time_ff;
   logic [CntW-1:0]   cnt_ff;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_kind_ff;
   logic [DeltaW-1:0] rsp_delta_ff[4];
   logic [DurW-1:0]   rsp_dur_ff;

   // shared units
   logic [CoordW-1:0] op_a;
   logic [CoordW-1:0] op_b;
   logic [ProdW-1:0]  product;
   logic              sq_start;
   logic [RadW-1:0]   sq_rad;
   unit_stat_type     sq_stat;
   logic [RootW-1:0]  sq_root;
   logic              dv_start;
   logic [DvdW-1:0]   dv_dividend;
   unit_stat_type     dv_stat;
   logic [DvdW-1:0]   dv_quot;
   logic [RootW-1:0]  dist_max;

   // issue side of the multiplier sequence
   logic [1:0]        iss_k;
   logic [CoordW:0]   diff;
   logic [CoordW:0]   diff_abs;
   logic [CoordW-1:0] mag;

   // capture side of the multiplier sequence
   logic [CntW-1:0]          cap;
   logic [1:0]               cap_k;
   logic                     cap_en;
   logic                     mul_last;
   logic [CoordW-1:0]        ip;
   logic                     frac_nz;
   logic                     cneg;
   logic signed [WideW-1:0]  hi_s;
   logic signed [WideW-1:0]  dr_s;
   logic signed [WideW-1:0]  dadj_s;
   logic [DeltaW-1:0]        dclamp;
   logic [CoordW-1:0]        trunc;

   // finish
   logic              all_zero;
   logic              single;
   logic              out_free;
   logic              emit;
   logic [DurW-1:0]   move_time;

   ptsc_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   ptsc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .stat     (sq_stat),
      .root     (sq_root)
   );

   ptsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (speed_ff),
      .stat     (dv_stat),
      .quotient (dv_quot)
   );

   // operand select: magnitudes times scale, then squared side differences
   assign iss_k    = cnt_ff[1:0];
   assign mag      = pt_ff[iss_k][CoordW-1] ? (~pt_ff[iss_k] + 1'b1) : pt_ff[iss_k];
   assign diff     = {pt_ff[iss_k][CoordW-1], pt_ff[iss_k]}
                   - {prev_ff[iss_k][CoordW-1], prev_ff[iss_k]};
   assign diff_abs = diff[CoordW] ? (~diff + 1'b1) : diff;

   always_comb begin
      if (cnt_ff[2]) begin
         op_a = diff_abs[CoordW-1:0];
         op_b = diff_abs[CoordW-1:0];
      end else begin
         op_a = mag;
         op_b = iss_k[0] ? y_scale_ff : x_scale_ff;
      end
   end

   // capture: split product into integer and fraction of the target
   assign cap      = cnt_ff - CntW'(MulLat);
   assign cap_k    = cap[1:0];
   assign cap_en   = (state_ff == ST_MUL) && (cnt_ff >= CntW'(MulLat));
   assign mul_last = cnt_ff == (start_ff ? CntW'(AxisOps + MulLat - 1)
                                         : CntW'(AllOps + MulLat - 1));
   assign ip       = product[ProdW-1:CoordW];
   assign frac_nz  = |product[CoordW-1:0];
   assign cneg     = pt_ff[cap_k][CoordW-1];
   assign trunc    = cneg ? (~ip + 1'b1) : ip;

   always_comb begin
      // floor of the target, minus position, rounded toward zero
      if (cneg) begin
         hi_s = -$signed({3'b000, ip}) - $signed({{(WideW-1){1'b0}}, frac_nz});
      end else begin
         hi_s = $signed({3'b000, ip});
      end
      dr_s   = hi_s - $signed({{3{pos_ff[cap_k][CoordW-1]}}, pos_ff[cap_k]});
      dadj_s = (dr_s[WideW-1] && frac_nz) ? (dr_s + WideW'(1)) : dr_s;
      // clamp to the delta range
      if (dadj_s > $signed(WideW'(32767))) begin
         dclamp = 16'h7FFF;
      end else if (dadj_s < -$signed(WideW'(32768))) begin
         dclamp = 16'h8000;
      end else begin
         dclamp = dadj_s[DeltaW-1:0];
      end
   end

   // root and division starts
   assign sq_start    = ((state_ff == ST_MUL) && mul_last && !start_ff) ||
                        ((state_ff == ST_ROOT_L) && sq_stat.done);
   assign sq_rad      = (state_ff == ST_MUL) ? sum_ff[0] : sum_ff[1];
   assign dist_max    = (dist_l_ff > sq_root) ? dist_l_ff : sq_root;
   assign dv_start    = (state_ff == ST_ROOT_R) && sq_stat.done;
   assign dv_dividend = {dist_max, {FracW{1'b0}}};
   assign move_time   = (|dv_quot[DvdW-1:DurW]) ? {DurW{1'b1}} : dv_quot[DurW-1:0];

   // command classification
   always_comb begin
      all_zero = 1'b1;
      single   = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (delta_ff[k] != '0) all_zero = 1'b0;
         if (delta_ff[k] != '0 && delta_ff[k] != 16'h0001 && delta_ff[k] != 16'hFFFF)
            single = 1'b0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit     = (state_ff == ST_DONE) && !all_zero && out_free;

   // sequencer, path state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         start_ff     <= 1'b0;
         x_scale_ff   <= ScaleReset;
         y_scale_ff   <= ScaleReset;
         speed_ff     <= ScaleReset;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            prev_ff[k] <= '0;
            pos_ff[k]  <= '0;
         end
      end else begin
         // configuration beats
         if (csr_ch.valid) begin
            case (csr_addr_type'(csr_ch.addr))
               CSR_X_SCALE: x_scale_ff <= csr_ch.data;
               CSR_Y_SCALE: y_scale_ff <= csr_ch.data;
               CSR_SPEED:   speed_ff   <= csr_ch.data;
               default:     ;
            endcase
         end

         // load a new output beat, or drop the held one once taken
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  pt_ff[0] <= req_ch.left_x;
                  pt_ff[1] <= req_ch.left_y;
                  pt_ff[2] <= req_ch.right_x;
                  pt_ff[3] <= req_ch.right_y;
                  start_ff <= req_ch.start_req;
                  cnt_ff   <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cap_en) begin
                  if (!cap[2]) begin
                     if (start_ff) pos_ff[cap_k]   <= trunc;
                     else          delta_ff[cap_k] <= dclamp;
                  end else if (!cap[0]) begin
                     sum_ff[cap[1]] <= {2'b00, product};
                  end else begin
                     sum_ff[cap[1]] <= sum_ff[cap[1]] + {2'b00, product};
                  end
               end
               if (mul_last) begin
                  if (start_ff) begin
                     // start point: load previous point, clear skipped time
                     for (int k = 0; k < 4; k++) prev_ff[k] <= pt_ff[k];
                     skip_ff  <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_ROOT_L;
                  end
               end
            end
            ST_ROOT_L: begin
               if (sq_stat.done) begin
                  dist_l_ff <= sq_root;
                  state_ff  <= ST_ROOT_R;
               end
            end
            ST_ROOT_R: begin
               if (sq_stat.done) state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (dv_stat.done) begin
                  time_ff  <= move_time;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (all_zero) begin
                  // skip: keep the time for the next command
                  for (int k = 0; k < 4; k++) prev_ff[k] <= pt_ff[k];
                  skip_ff  <= sat_add(skip_ff, time_ff);
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  // emit the command and advance positions
                  for (int k = 0; k < 4; k++) begin
                     prev_ff[k]      <= pt_ff[k];
                     pos_ff[k]       <= pos_ff[k] + {{(CoordW-DeltaW){delta_ff[k][DeltaW-1]}},
                                                     delta_ff[k]};
                     rsp_delta_ff[k] <= delta_ff[k];
                  end
                  rsp_kind_ff  <= !single;
                  rsp_dur_ff   <= sat_add(time_ff, skip_ff);
                  skip_ff      <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = rsp_kind_ff;
   assign rsp_ch.delta_left_x  = rsp_delta_ff[0];
   assign rsp_ch.delta_left_y  = rsp_delta_ff[1];
   assign rsp_ch.delta_right_x = rsp_delta_ff[2];
   assign rsp_ch.delta_right_y = rsp_delta_ff[3];
   assign rsp_ch.duration      = rsp_dur_ff;

endmodule

// ----- rtl/ptsc_mul.sv -----
// Shared 32x32 unsigned multiplier with registered operands and product.
module ptsc_mul
   import ptsc_pkg::*;
(
   input  logic             clock,
   input  logic [CoordW-1:0] op_a,
   input  logic [CoordW-1:0] op_b,
   output logic [ProdW-1:0]  product
);

   logic [CoordW-1:0] a_ff;
   logic [CoordW-1:0] b_ff;
   logic [ProdW-1:0]  prod_ff;
   logic [ProdW-1:0]  prod_in;

   // full-width product of the held operands
   assign prod_in = a_ff * b_ff;

   // register operands, then the product
   always_ff @(posedge clock) begin
      a_ff    <= op_a;
      b_ff    <= op_b;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// ----- rtl/ptsc_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module ptsc_sqrt
   import ptsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RadW-1:0]   radicand,
   output unit_stat_type     stat,
   output logic [RootW-1:0]  root
);

   localparam int RemW = RootW + 4;
   localparam int CntW = $clog2(RootW + 1);

   logic [RadW-1:0]  rad_ff;
   logic [RemW-1:0]  rem_ff;
   logic [RootW-1:0] root_ff;
   logic [CntW-1:0]  cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [RemW-1:0]  rem_sh;
   logic [RemW-1:0]  trial;
   logic             fits;

   // bring down the next bit pair and try root*4+1
   assign rem_sh = {rem_ff[RemW-3:0], rad_ff[RadW-1 -: 2]};
   assign trial  = {{(RemW-RootW-2){1'b0}}, root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // load operand, clear partial results
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= CntW'(RootW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // advance one bit pair
            rad_ff  <= {rad_ff[RadW-3:0], 2'b00};
            rem_ff  <= fits ? (rem_sh - trial) : rem_sh;
            root_ff <= {root_ff[RootW-2:0], fits};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

// ----- rtl/ptsc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module ptsc_div
   import ptsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DvdW-1:0]   dividend,
   input  logic [ScaleW-1:0] divisor,
   output unit_stat_type     stat,
   output logic [DvdW-1:0]   quotient
);

   localparam int CntW = $clog2(DvdW + 1);

   // dividend shifts out at the top while quotient bits shift in below
   logic [DvdW-1:0]   dq_ff;
   logic [ScaleW-1:0] dsr_ff;
   logic [ScaleW-1:0] rem_ff;
   logic [CntW-1:0]   cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [ScaleW:0]   rem_sh;
   logic [ScaleW:0]   rem_sub;
   logic              fits;

   assign rem_sh  = {rem_ff, dq_ff[DvdW-1]};
   assign fits    = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dq_ff   <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= CntW'(DvdW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // subtract where the divisor fits, keep the remainder otherwise
            rem_ff <= fits ? rem_sub[ScaleW-1:0] : rem_sh[ScaleW-1:0];
            dq_ff  <= {dq_ff[DvdW-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dq_ff;

endmodule

// ----- rtl/ptsc_checker.sv -----
// Port-level checks on the path-to-stepper block, bound to the top level.
module ptsc_checker
   import ptsc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_kind,
   input logic [DeltaW-1:0] rsp_dlx,
   input logic [DeltaW-1:0] rsp_dly,
   input logic [DeltaW-1:0] rsp_drx,
   input logic [DeltaW-1:0] rsp_dry,
   input logic [DurW-1:0]   rsp_duration
);

   // no command straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // a stalled command holds its duration and kind
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duration) && $stable(rsp_kind))
      else $error("stalled result beat changed");

   // one point at a time: no input beat right after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a point is in work");

   // single step commands move each axis by at most one step
   a_single_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |->
         (rsp_dlx == 16'h0000 || rsp_dlx == 16'h0001 || rsp_dlx == 16'hFFFF) &&
         (rsp_dly == 16'h0000 || rsp_dly == 16'h0001 || rsp_dly == 16'hFFFF) &&
         (rsp_drx == 16'h0000 || rsp_drx == 16'h0001 || rsp_drx == 16'hFFFF) &&
         (rsp_dry == 16'h0000 || rsp_dry == 16'h0001 || rsp_dry == 16'hFFFF))
      else $error("single step command with a large delta");

endmodule

bind path_to_stepper_commands ptsc_checker u_ptsc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_dlx      (rsp_ch.delta_left_x),
   .rsp_dly      (rsp_ch.delta_left_y),
   .rsp_drx      (rsp_ch.delta_right_x),
   .rsp_dry      (rsp_ch.delta_right_y),
   .rsp_duration (rsp_ch.duration)
);
